### sv/oss_pkg.sv
// Package for the outside score span table.
// Holds field widths, operation codes and the query stage record.
// No dependencies.
package oss_pkg;

	localparam int OP_W    = 2;
	localparam int SCORE_W = 16;
	localparam int SPAN_W  = 9;
	localparam int SUM_W   = 24;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	typedef logic [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic bad_span;
		logic start_zero;
		logic start_total;
		logic end_zero;
		logic end_total;
		sum_t total;
	} oss_query_t;

endpackage

### sv/oss_store.sv
// Word score store: word count, running total and the prefix sum memory.
// Decodes each accepted word and registers the query lookup into stage one.
// Depends on oss_pkg.
module oss_store import oss_pkg::*; #(
	parameter int MAX_WORDS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_fire,
	input  logic [OP_W-1:0]          opcode,
	input  logic signed [SCORE_W-1:0] score,
	input  logic [SPAN_W-1:0]        span_start,
	input  logic [SPAN_W-1:0]        span_end,
	output logic                     query_load,
	output oss_query_t               query_s1,
	output sum_t                     start_data_s1,
	output sum_t                     end_data_s1
);

	localparam int CNT_W = $clog2(MAX_WORDS + 1);
	localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CMP_W = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;

	logic [CNT_W-1:0] count_q;
	sum_t             total_q;
	sum_t             prefix_mem [MAX_WORDS];

	logic             do_append;
	sum_t             new_total;
	logic [CMP_W-1:0] start_ext;
	logic [CMP_W-1:0] end_ext;
	logic [CMP_W-1:0] count_ext;
	logic [AW-1:0]    start_addr;
	logic [AW-1:0]    end_addr;
	oss_query_t       query_d;

	assign do_append  = in_fire && (opcode == OP_APPEND) && (count_q < CNT_W'(MAX_WORDS));
	assign new_total  = total_q + {{(SUM_W-SCORE_W){score[SCORE_W-1]}}, score};
	assign query_load = in_fire && (opcode == OP_QUERY);

	assign start_ext  = CMP_W'(span_start);
	assign end_ext    = CMP_W'(span_end);
	assign count_ext  = CMP_W'(count_q);
	assign start_addr = AW'(start_ext - CMP_W'(1));
	assign end_addr   = AW'(end_ext - CMP_W'(1));

	always_comb begin
		query_d.bad_span    = (start_ext > end_ext) || (end_ext > count_ext);
		query_d.start_zero  = (start_ext == '0);
		query_d.start_total = (start_ext >= count_ext);
		query_d.end_zero    = (end_ext == '0);
		query_d.end_total   = (end_ext >= count_ext);
		query_d.total       = total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (in_fire) begin
			if (opcode == OP_CLEAR) begin
				count_q <= '0;
				total_q <= '0;
			end else if (do_append) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= new_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_append) begin
			prefix_mem[count_q[AW-1:0]] <= new_total;
		end
	end

	always_ff @(posedge clk) begin
		if (query_load) begin
			query_s1      <= query_d;
			start_data_s1 <= prefix_mem[start_addr];
			end_data_s1   <= prefix_mem[end_addr];
		end
	end

endmodule

### sv/oss_combine.sv
// Result stage: forms prefix(i) + total - prefix(j) and holds the result word.
// Owns the stage one and output valid flags and the backpressure.
// Depends on oss_pkg.
module oss_combine import oss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_load,
	input  oss_query_t        query_s1,
	input  sum_t              start_data_s1,
	input  sum_t              end_data_s1,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [SUM_W-1:0] outside_score,
	output logic              error
);

	logic s1_valid_q;
	logic out_valid_q;
	logic advance;
	sum_t start_sum;
	sum_t end_sum;
	sum_t result;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !s1_valid_q || advance;
	assign out_valid = out_valid_q;

	always_comb begin
		if (query_s1.start_zero) begin
			start_sum = '0;
		end else if (query_s1.start_total) begin
			start_sum = query_s1.total;
		end else begin
			start_sum = start_data_s1;
		end
		if (query_s1.end_zero) begin
			end_sum = '0;
		end else if (query_s1.end_total) begin
			end_sum = query_s1.total;
		end else begin
			end_sum = end_data_s1;
		end
		result = start_sum + query_s1.total - end_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (query_load) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			outside_score <= query_s1.bad_span ? '0 : result;
			error         <= query_s1.bad_span;
		end
	end

endmodule

### sv/outside_score_span_table.sv
// Outside score span table, top level: clear, append and span query words.
// Depends on oss_pkg, oss_store and oss_combine.
//
//   channel | signals                                    | direction
//   input   | in_valid, in_ready, opcode, score,          | into block
//           | span_start, span_end                       |
//   result  | out_valid, out_ready, outside_score, error | out of block
//
// One input word is taken every cycle while in_ready is high. A query's result word
// passes through the registered prefix memory read and then the add and subtract
// into the result register. Clear and append give no result.
// Reset clears the word count and total; the prefix memory needs no clearing pass.
// A stalled result holds the stage behind it; input is refused only when both
// stages are full.
module outside_score_span_table import oss_pkg::*; #(
	parameter int MAX_WORDS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [OP_W-1:0]           opcode,
	input  logic signed [SCORE_W-1:0] score,
	input  logic [SPAN_W-1:0]         span_start,
	input  logic [SPAN_W-1:0]         span_end,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [SUM_W-1:0]   outside_score,
	output logic                      error
);

	logic       in_fire;
	logic       query_load;
	oss_query_t query_s1;
	sum_t       start_data_s1;
	sum_t       end_data_s1;

	assign in_fire = in_valid && in_ready;

	oss_store #(
		.MAX_WORDS(MAX_WORDS)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.opcode       (opcode),
		.score        (score),
		.span_start   (span_start),
		.span_end     (span_end),
		.query_load   (query_load),
		.query_s1     (query_s1),
		.start_data_s1(start_data_s1),
		.end_data_s1  (end_data_s1)
	);

	oss_combine u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_load   (query_load),
		.query_s1     (query_s1),
		.start_data_s1(start_data_s1),
		.end_data_s1  (end_data_s1),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.outside_score(outside_score),
		.error        (error)
	);

endmodule

### sv/oss_checker.sv
// Port checker for the outside score span table, bound to the top level.
// Depends on oss_pkg.
module oss_checker import oss_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [OP_W-1:0]           opcode,
	input logic [SPAN_W-1:0]         span_start,
	input logic [SPAN_W-1:0]         span_end,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [SUM_W-1:0]   outside_score,
	input logic                      error
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outside_score) && $stable(error))
		else $error("result word changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> outside_score == '0)
		else $error("error result carries a nonzero score");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && opcode == OP_QUERY, 2))
		else $error("result word without a query two cycles earlier");

	a_start_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_QUERY && span_start > span_end && !out_valid
		&& !$past(in_valid && in_ready && opcode == OP_QUERY)
		|=> ##1 out_valid && error)
		else $error("span with start after end did not report an error");

endmodule

bind outside_score_span_table oss_checker u_oss_checker (.*);
